FILE: design/cvcl_pkg.sv
// Shared types and constants of the cascaded voltage/current loop.
// Used by cvcl_ctrl, cvcl_datapath and cascaded_voltage_current_loop_unit.
`default_nettype none

package cvcl_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 18;

    localparam int ERR_W     = 24;
    localparam int IREF_W    = 32;
    localparam int STATE_W   = 18;
    localparam int DUTY_W    = 17;
    localparam int COEF_FRAC = 14;
    localparam int DUTY_SHIFT = 8;
    localparam int DUTY_ONE  = 65536;
    localparam int DUTY_LOW  = -6554;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_VOLT_NUM_NOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_NUM_PREV = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_DEN_PREV = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CUR_NUM_NOW   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CUR_NUM_PREV  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CUR_DEN_PREV  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_UPPER    = 3'd6;

    localparam logic [DUTY_W-1:0] UPPER_RESET = 17'd65536;

    typedef enum logic [2:0] {
        MUL_VE,
        MUL_PVE,
        MUL_PIR,
        MUL_EI,
        MUL_PCE,
        MUL_PD
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_SHIFT_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_VE,
        ST_MUL_PVE,
        ST_MUL_PIR,
        ST_ACC_IR,
        ST_IREF,
        ST_MUL_EI,
        ST_MUL_PCE,
        ST_MUL_PD,
        ST_ACC_D,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     iref_en;
        logic     commit;
    } cmd_t;

    function automatic int cfg_width(input int coef_width);
        return (coef_width > DUTY_W) ? coef_width : DUTY_W;
    endfunction

endpackage

`default_nettype wire

FILE: design/cascaded_voltage_current_loop_unit.sv
// Cascaded voltage/current loop: top level joining the sequencer and the datapath.
// Depends on cvcl_pkg, cvcl_ctrl and cvcl_datapath.
//
// Usage:
//   s_axis_*  takes one sample request: voltage reference, measured output voltage
//             and inductor current in tdata, the clear-history flag in tuser.
//   m_axis_*  returns one result per request: duty (Q1.16) in tdata, the
//             saturation flag in tuser.
//   cfg_*     writes one register per cycle at cfg_we; index 0..5 are the loop
//             coefficients, 6 the duty upper limit, other indexes are ignored.
//             Write only while no request is in flight.
// Timing: a request is taken in the idle state and the result is loaded into the
//   output register in the finish state; the next request is taken only after the
//   result is loaded. The six products run one after another on a single multiplier
//   with a registered product.
// Reset clears the history to zero, the coefficients to zero and the upper limit
//   to one. When the receiver stalls, the result stays in the output register
//   while the next request is already taken and computed; that one waits in the
//   last step until the register is free.
`default_nettype none

module cascaded_voltage_current_loop_unit
    import cvcl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // voltage_ref, voltage_out, inductor_current
    input  wire logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // clear_history
    input  wire logic [0:0]                             s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // duty
    output logic [23:0]                                 m_axis_tdata,
    // saturated
    output logic [0:0]                                  m_axis_tuser,
    input  wire logic                                   cfg_we,
    input  wire logic [REG_IDX_W-1:0]                   cfg_index,
    input  wire logic [cfg_width(COEF_WIDTH)-1:0]       cfg_data
);

    cmd_t              cmd;
    logic [DUTY_W-1:0] duty;
    logic              saturated;

    cvcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    cvcl_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .voltage_ref      (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .voltage_out      (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .inductor_current (s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
        .clear_history    (s_axis_tuser[0]),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .duty             (duty),
        .saturated        (saturated)
    );

    assign m_axis_tdata = {{(24-DUTY_W){1'b0}}, duty};
    assign m_axis_tuser = saturated;

    // a result goes to the output register only when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending result");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'd65536))
        else $error("duty above one");

endmodule

`default_nettype wire

FILE: design/cvcl_ctrl.sv
// Sequencer of the cascaded loop: one request at a time, six products on one multiplier.
// Depends on cvcl_pkg for the state and command types.
`default_nettype none

module cvcl_ctrl
    import cvcl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.mul_sel = MUL_VE;
        cmd.acc_op  = ACC_HOLD;
        cmd.iref_en = 1'b0;
        cmd.commit  = 1'b0;
        in_ready    = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL_VE;
                end
            end
            ST_MUL_VE:
            begin
                cmd.mul_sel = MUL_VE;
                state_next  = ST_MUL_PVE;
            end
            ST_MUL_PVE:
            begin
                cmd.mul_sel = MUL_PVE;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL_PIR;
            end
            ST_MUL_PIR:
            begin
                cmd.mul_sel = MUL_PIR;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_ACC_IR;
            end
            ST_ACC_IR:
            begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_IREF;
            end
            ST_IREF:
            begin
                cmd.iref_en = 1'b1;
                state_next  = ST_MUL_EI;
            end
            ST_MUL_EI:
            begin
                cmd.mul_sel = MUL_EI;
                state_next  = ST_MUL_PCE;
            end
            ST_MUL_PCE:
            begin
                cmd.mul_sel = MUL_PCE;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL_PD;
            end
            ST_MUL_PD:
            begin
                cmd.mul_sel = MUL_PD;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_ACC_D;
            end
            ST_ACC_D:
            begin
                cmd.acc_op = ACC_SHIFT_SUB;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/cvcl_datapath.sv
// Datapath of the cascaded loop: registers, history, one shared multiplier, accumulator,
// rounding, saturation and duty clamps. Depends on cvcl_pkg.
`default_nettype none

module cvcl_datapath
    import cvcl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = COEF_WIDTH_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cmd_t                                 cmd,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       voltage_ref,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       voltage_out,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       inductor_current,
    input  wire logic                                 clear_history,
    input  wire logic                                 cfg_we,
    input  wire logic [REG_IDX_W-1:0]                 cfg_index,
    input  wire logic [cfg_width(COEF_WIDTH)-1:0]     cfg_data,
    output logic [DUTY_W-1:0]                         duty,
    output logic                                      saturated
);

    localparam int MUL_B_W = IREF_W;
    localparam int PROD_W  = COEF_WIDTH + MUL_B_W;
    localparam int ACC_W   = COEF_WIDTH + 34;
    localparam int RQ_W    = ACC_W - COEF_FRAC;

    // configuration
    logic signed [COEF_WIDTH-1:0] volt_num_now_reg;
    logic signed [COEF_WIDTH-1:0] volt_num_prev_reg;
    logic signed [COEF_WIDTH-1:0] volt_den_prev_reg;
    logic signed [COEF_WIDTH-1:0] cur_num_now_reg;
    logic signed [COEF_WIDTH-1:0] cur_num_prev_reg;
    logic signed [COEF_WIDTH-1:0] cur_den_prev_reg;
    logic [DUTY_W-1:0]            upper_reg;

    // history
    logic signed [ERR_W-1:0]   prev_ve_reg;
    logic signed [IREF_W-1:0]  prev_ir_reg;
    logic signed [ERR_W-1:0]   prev_ei_reg;
    logic signed [STATE_W-1:0] prev_d_reg;

    // working registers
    logic signed [ERR_W-1:0]        ev_reg;
    logic signed [SAMPLE_WIDTH-1:0] il_reg;
    logic signed [IREF_W-1:0]       ir_reg;
    logic signed [ERR_W-1:0]        ei_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           sat_reg;
    logic [DUTY_W-1:0]              duty_reg;
    logic                           sat_out_reg;

    logic signed [SAMPLE_WIDTH:0]   ev_diff;
    logic signed [ERR_W:0]          ev_wide;
    logic                           ev_sat;
    logic signed [ERR_W-1:0]        ev_val;
    logic signed [COEF_WIDTH-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]       mul_a_ext;
    logic signed [PROD_W-1:0]       mul_b_ext;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        rsum;
    logic signed [RQ_W-1:0]         rq;
    logic [RQ_W-IREF_W:0]           rq_top;
    logic                           ir_sat;
    logic signed [IREF_W-1:0]       ir_val;
    logic signed [IREF_W:0]         ei_diff;
    logic [IREF_W-ERR_W+1:0]        ei_top;
    logic                           ei_sat;
    logic signed [ERR_W-1:0]        ei_val;
    logic signed [RQ_W-1:0]         upper_ext;
    logic signed [RQ_W-1:0]         low_ext;
    logic signed [STATE_W-1:0]      d_val;
    logic [DUTY_W-1:0]              duty_val;

    // voltage error, saturated to the error width
    always_comb
    begin
        ev_diff = (SAMPLE_WIDTH + 1)'(voltage_ref) - (SAMPLE_WIDTH + 1)'(voltage_out);
        ev_wide = (ERR_W + 1)'(ev_diff);
        ev_sat  = ev_wide[ERR_W] != ev_wide[ERR_W-1];
        if (ev_sat)
            ev_val = ev_wide[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        else
            ev_val = ev_wide[ERR_W-1:0];
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_VE:
            begin
                mul_a = volt_num_now_reg;
                mul_b = MUL_B_W'(ev_reg);
            end
            MUL_PVE:
            begin
                mul_a = volt_num_prev_reg;
                mul_b = MUL_B_W'(prev_ve_reg);
            end
            MUL_PIR:
            begin
                mul_a = volt_den_prev_reg;
                mul_b = prev_ir_reg;
            end
            MUL_EI:
            begin
                mul_a = cur_num_now_reg;
                mul_b = MUL_B_W'(ei_reg);
            end
            MUL_PCE:
            begin
                mul_a = cur_num_prev_reg;
                mul_b = MUL_B_W'(prev_ei_reg);
            end
            MUL_PD:
            begin
                mul_a = cur_den_prev_reg;
                mul_b = MUL_B_W'(prev_d_reg);
            end
            default:
            begin
                mul_a = volt_num_now_reg;
                mul_b = MUL_B_W'(ev_reg);
            end
        endcase
        mul_a_ext = PROD_W'(mul_a);
        mul_b_ext = PROD_W'(mul_b);
        prod_ext  = ACC_W'(prod_reg);
    end

    // round half up by 2^-14, then saturate to the current reference width
    always_comb
    begin
        rsum   = acc_reg + ACC_W'(1 << (COEF_FRAC - 1));
        rq     = rsum[ACC_W-1:COEF_FRAC];
        rq_top = rq[RQ_W-1:IREF_W-1];
        ir_sat = !((&rq_top) || !(|rq_top));
        if (ir_sat)
            ir_val = rq[RQ_W-1] ? {1'b1, {(IREF_W-1){1'b0}}} : {1'b0, {(IREF_W-1){1'b1}}};
        else
            ir_val = rq[IREF_W-1:0];

        ei_diff = (IREF_W + 1)'(ir_val) - (IREF_W + 1)'(il_reg);
        ei_top  = ei_diff[IREF_W:ERR_W-1];
        ei_sat  = !((&ei_top) || !(|ei_top));
        if (ei_sat)
            ei_val = ei_diff[IREF_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        else
            ei_val = ei_diff[ERR_W-1:0];
    end

    // duty state clamp, then output clamp to [0, 1]
    always_comb
    begin
        upper_ext = RQ_W'($signed({1'b0, upper_reg}));
        low_ext   = RQ_W'(DUTY_LOW);
        if (rq > upper_ext)
            d_val = STATE_W'(upper_ext);
        else if (rq < low_ext)
            d_val = STATE_W'(low_ext);
        else
            d_val = STATE_W'(rq);

        if (d_val < 0)
            duty_val = '0;
        else if (d_val > STATE_W'(DUTY_ONE))
            duty_val = DUTY_W'(DUTY_ONE);
        else
            duty_val = d_val[DUTY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_num_now_reg  <= '0;
            volt_num_prev_reg <= '0;
            volt_den_prev_reg <= '0;
            cur_num_now_reg   <= '0;
            cur_num_prev_reg  <= '0;
            cur_den_prev_reg  <= '0;
            upper_reg         <= UPPER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VOLT_NUM_NOW:  volt_num_now_reg  <= cfg_data[COEF_WIDTH-1:0];
                REG_VOLT_NUM_PREV: volt_num_prev_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_VOLT_DEN_PREV: volt_den_prev_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_CUR_NUM_NOW:   cur_num_now_reg   <= cfg_data[COEF_WIDTH-1:0];
                REG_CUR_NUM_PREV:  cur_num_prev_reg  <= cfg_data[COEF_WIDTH-1:0];
                REG_CUR_DEN_PREV:  cur_den_prev_reg  <= cfg_data[COEF_WIDTH-1:0];
                REG_DUTY_UPPER:    upper_reg         <= cfg_data[DUTY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ve_reg <= '0;
            prev_ir_reg <= '0;
            prev_ei_reg <= '0;
            prev_d_reg  <= '0;
        end
        else if (cmd.load_in && clear_history)
        begin
            prev_ve_reg <= '0;
            prev_ir_reg <= '0;
            prev_ei_reg <= '0;
            prev_d_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            prev_ve_reg <= ev_reg;
            prev_ir_reg <= ir_reg;
            prev_ei_reg <= ei_reg;
            prev_d_reg  <= d_val;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a_ext * mul_b_ext;
        case (cmd.acc_op)
            ACC_LOAD:      acc_reg <= prod_ext;
            ACC_ADD:       acc_reg <= acc_reg + prod_ext;
            ACC_SUB:       acc_reg <= acc_reg - prod_ext;
            ACC_SHIFT_SUB: acc_reg <= (acc_reg <<< DUTY_SHIFT) - prod_ext;
            default:       acc_reg <= acc_reg;
        endcase
        if (cmd.load_in)
        begin
            ev_reg  <= ev_val;
            il_reg  <= inductor_current;
            sat_reg <= ev_sat;
        end
        if (cmd.iref_en)
        begin
            ir_reg  <= ir_val;
            ei_reg  <= ei_val;
            sat_reg <= sat_reg || ir_sat || ei_sat;
        end
        if (cmd.commit)
        begin
            duty_reg    <= duty_val;
            sat_out_reg <= sat_reg;
        end
    end

    assign duty      = duty_reg;
    assign saturated = sat_out_reg;

endmodule

`default_nettype wire
